// File: hdl/sac_pkg.sv
// shared types, codes and helper functions of the cache tag controller
package sac_pkg;

    localparam int ADDR_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int WAY_OUT_W = 3;
    localparam int WB_ADDR_W = 26;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'd1;

    // per-entry layout inside a set row: valid, dirty, tag, stamp from the lsb up
    localparam int ENT_VALID = 0;
    localparam int ENT_DIRTY = 1;
    localparam int ENT_TAG   = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic hit;
        logic has_free;
    } way_flags_t;

    function automatic int floor_log2(input int value);
        int n;
        int v;
        n = 0;
        v = value;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// File: hdl/sac_tag_ram.sv
// set row memory: one write port, one registered read port
module sac_tag_ram #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DATA_W = 432
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/sac_way_match.sv
// tag compare and free-way search across the ways of one set row
module sac_way_match #(
    parameter int NUM_WAYS = 8,
    parameter int WAY_W    = 3,
    parameter int TAG_W    = 20,
    parameter int ENTRY_W  = 54
) (
    input  logic [NUM_WAYS*ENTRY_W-1:0] row,
    input  logic [TAG_W-1:0]            tag,
    output sac_pkg::way_flags_t         flags,
    output logic [WAY_W-1:0]            hit_way,
    output logic [WAY_W-1:0]            free_way
);
    import sac_pkg::*;

    // walk from the top down so the lowest way wins
    always_comb begin
        flags    = '0;
        hit_way  = '0;
        free_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (row[w*ENTRY_W + ENT_VALID] && (row[w*ENTRY_W + ENT_TAG +: TAG_W] == tag)) begin
                flags.hit = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!row[w*ENTRY_W + ENT_VALID]) begin
                flags.has_free = 1'b1;
                free_way       = WAY_W'(w);
            end
        end
    end

endmodule

// File: hdl/set_assoc_cache_tag_controller.sv
// set-associative cache tag controller with lru replacement and write-back reporting
// a hit, a free-way miss or a forwarded write is resolved in the lookup state once the output register is free
// a miss into a full set scans the lru stamps (one way's stamp compared per cycle), then installs in the commit state
// one item at a time: s_ready is high only in idle, so a new item waits until the current result is loaded
// reset: synchronous active-low; afterwards a clearing pass writes 2^floor(log2(NUM_SETS))
// rows, one per cycle, during which no item is accepted (config writes still taken)
module set_assoc_cache_tag_controller #(
    parameter int NUM_SETS    = 64,
    parameter int NUM_WAYS    = 8,
    parameter int BLOCK_BYTES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_write_en,
    input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // access items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [sac_pkg::ADDR_W-1:0]       s_byte_address,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [sac_pkg::WAY_OUT_W-1:0]    m_way,
    output logic                             m_fill_request,
    output logic                             m_writeback_needed,
    output logic [sac_pkg::WB_ADDR_W-1:0]    m_writeback_block_address,
    output logic                             m_forward_write
);
    import sac_pkg::*;

    // address split
    localparam int OB      = floor_log2(BLOCK_BYTES);
    localparam int SB      = floor_log2(NUM_SETS);
    localparam int TAG_W   = ADDR_W - OB - SB;
    localparam int SET_W   = (SB > 0) ? SB : 1;
    localparam int ROWS    = 1 << SB;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    // one set row holds every way's valid, dirty, tag and stamp
    localparam int STAMP_LSB = ENT_TAG + TAG_W;
    localparam int ENTRY_W   = STAMP_LSB + STAMP_W;
    localparam int ROW_W     = NUM_WAYS * ENTRY_W;
    localparam logic [SET_W-1:0] LAST_ROW = SET_W'(ROWS - 1);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

    ctrl_state_t state_reg, state_next;

    // configuration registers
    logic wb_mode_reg;
    logic alloc_mode_reg;

    // item held while it is looked up
    logic              op_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [STAMP_W-1:0] count_reg;

    // clear pass and lru scan
    logic [SET_W-1:0]   clr_reg, clr_next;
    logic [WAY_W-1:0]   scan_reg, scan_next;
    logic [WAY_W-1:0]   victim_reg, victim_next;
    logic [STAMP_W-1:0] best_reg, best_next;

    // output register
    logic                 m_valid_reg;
    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic                 fill_reg;
    logic                 wb_reg;
    logic [WB_ADDR_W-1:0] wb_addr_reg;
    logic                 fwd_reg;

    // memory ports
    logic              ram_wr_en;
    logic [SET_W-1:0]  ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [ROW_W-1:0]  rd_row;

    // lookup
    way_flags_t        flags;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;

    logic              accept;
    logic              out_free;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;

    // datapath decisions
    logic                 load_out;
    logic                 go_scan;
    logic                 scan_done;
    logic                 install;
    logic [WAY_W-1:0]     inst_way;
    logic                 res_hit;
    logic [WAY_OUT_W-1:0] res_way;
    logic                 res_fill;
    logic                 res_wb;
    logic [WB_ADDR_W-1:0] res_wb_addr;
    logic                 res_fwd;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign in_set = (SB > 0) ? SET_W'(s_byte_address >> OB) : '0;
    assign in_tag = TAG_W'(s_byte_address >> (OB + SB));

    // set row is read on accept and stays on the read port until the next accept
    assign ram_rd_en = accept;

    sac_tag_ram #(
        .DEPTH  (ROWS),
        .AW     (SET_W),
        .DATA_W (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (in_set),
        .rd_data (rd_row)
    );

    sac_way_match #(
        .NUM_WAYS (NUM_WAYS),
        .WAY_W    (WAY_W),
        .TAG_W    (TAG_W),
        .ENTRY_W  (ENTRY_W)
    ) u_match (
        .row      (rd_row),
        .tag      (tag_reg),
        .flags    (flags),
        .hit_way  (hit_way),
        .free_way (free_way)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (go_scan) begin
                    state_next = ST_SCAN;
                end else if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [ENTRY_W-1:0] ent;
        logic [STAMP_W-1:0] cand;
        logic [ADDR_W-1:0]  blk;

        ram_wr_en   = 1'b0;
        ram_wr_addr = set_reg;
        ram_wr_data = rd_row;
        clr_next    = clr_reg;
        scan_next   = scan_reg;
        victim_next = victim_reg;
        best_next   = best_reg;
        load_out    = 1'b0;
        go_scan     = 1'b0;
        scan_done   = 1'b0;
        install     = 1'b0;
        inst_way    = victim_reg;
        res_hit     = 1'b0;
        res_way     = '0;
        res_fill    = 1'b0;
        res_wb      = 1'b0;
        res_wb_addr = '0;
        res_fwd     = 1'b0;
        ent         = '0;
        cand        = '0;
        blk         = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
            end
            ST_LOOKUP: begin
                if (flags.hit) begin
                    if (out_free) begin
                        // refresh stamp, a write marks the line dirty
                        ent = rd_row[hit_way*ENTRY_W +: ENTRY_W];
                        ent[STAMP_LSB +: STAMP_W] = count_reg;
                        ent[ENT_DIRTY] = ent[ENT_DIRTY] | (op_reg == OP_WRITE);
                        ram_wr_data[hit_way*ENTRY_W +: ENTRY_W] = ent;
                        ram_wr_en = 1'b1;
                        load_out  = 1'b1;
                        res_hit   = 1'b1;
                        res_way   = WAY_OUT_W'(hit_way);
                    end
                end else if ((op_reg == OP_WRITE) && !alloc_mode_reg) begin
                    // write miss without allocation goes downstream untouched
                    if (out_free) begin
                        load_out = 1'b1;
                        res_fwd  = 1'b1;
                    end
                end else if (flags.has_free || (NUM_WAYS == 1)) begin
                    if (out_free) begin
                        install  = 1'b1;
                        inst_way = flags.has_free ? free_way : '0;
                    end
                end else begin
                    // full set: start lru scan with way 0 as best so far
                    go_scan     = 1'b1;
                    best_next   = rd_row[STAMP_LSB +: STAMP_W];
                    victim_next = '0;
                    scan_next   = WAY_W'(1);
                end
            end
            ST_SCAN: begin
                cand = rd_row[scan_reg*ENTRY_W + STAMP_LSB +: STAMP_W];
                if (cand < best_reg) begin
                    best_next   = cand;
                    victim_next = scan_reg;
                end
                scan_next = scan_reg + 1'b1;
                scan_done = (scan_reg == LAST_WAY);
            end
            ST_COMMIT: begin
                if (out_free) begin
                    install  = 1'b1;
                    inst_way = victim_reg;
                end
            end
            default: begin
            end
        endcase

        if (install) begin
            // evict victim, report it if dirty in write-back mode, install new line
            ent = rd_row[inst_way*ENTRY_W +: ENTRY_W];
            blk = (ADDR_W'(ent[ENT_TAG +: TAG_W]) << SB) | ADDR_W'(set_reg);
            res_wb = wb_mode_reg && ent[ENT_VALID] && ent[ENT_DIRTY];
            res_wb_addr = res_wb ? blk[WB_ADDR_W-1:0] : '0;
            ent = '0;
            ent[ENT_VALID] = 1'b1;
            ent[ENT_DIRTY] = (op_reg == OP_WRITE);
            ent[ENT_TAG +: TAG_W] = tag_reg;
            ent[STAMP_LSB +: STAMP_W] = count_reg;
            ram_wr_data[inst_way*ENTRY_W +: ENTRY_W] = ent;
            ram_wr_en = 1'b1;
            load_out  = 1'b1;
            res_way   = WAY_OUT_W'(inst_way);
            res_fill  = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            count_reg      <= '0;
            wb_mode_reg    <= 1'b1;
            alloc_mode_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            // access counter bumps on accept, its new value is this item's stamp
            if (accept) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cfg_write_en) begin
                case (cfg_index)
                    CFG_WRITE_BACK:     wb_mode_reg    <= cfg_wdata[0];
                    CFG_WRITE_ALLOCATE: alloc_mode_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item, scan and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_opcode;
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        scan_reg   <= scan_next;
        victim_reg <= victim_next;
        best_reg   <= best_next;
        if (load_out) begin
            hit_reg     <= res_hit;
            way_reg     <= res_way;
            fill_reg    <= res_fill;
            wb_reg      <= res_wb;
            wb_addr_reg <= res_wb_addr;
            fwd_reg     <= res_fwd;
        end
    end

    assign m_valid                   = m_valid_reg;
    assign m_hit                     = hit_reg;
    assign m_way                     = way_reg;
    assign m_fill_request            = fill_reg;
    assign m_writeback_needed        = wb_reg;
    assign m_writeback_block_address = wb_addr_reg;
    assign m_forward_write           = fwd_reg;

endmodule

// File: hdl/sac_checker.sv
// port-level checks of the cache tag controller and their binding
module sac_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_hit,
    input logic [sac_pkg::WAY_OUT_W-1:0]    m_way,
    input logic                             m_fill_request,
    input logic                             m_writeback_needed,
    input logic [sac_pkg::WB_ADDR_W-1:0]    m_writeback_block_address,
    input logic                             m_forward_write
);
    import sac_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous one still in lookup");

    // a result is exactly one of hit, fill or forwarded write
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($onehot({m_hit, m_fill_request, m_forward_write})))
        else $error("result is not exactly one of hit, fill, forward");

    // the write-back address is zero on any result without a write-back
    a_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_writeback_needed) |-> (m_writeback_block_address == '0))
        else $error("write-back address without write-back");

    // forwarded write reports way zero and no write-back
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_forward_write) |-> ((m_way == '0) && !m_writeback_needed))
        else $error("forwarded write reports a way or write-back");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_way) && $stable(m_hit)))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_controller sac_checker u_sac_checker (
    .aclk                      (aclk),
    .aresetn                   (aresetn),
    .s_valid                   (s_valid),
    .s_ready                   (s_ready),
    .m_valid                   (m_valid),
    .m_ready                   (m_ready),
    .m_hit                     (m_hit),
    .m_way                     (m_way),
    .m_fill_request            (m_fill_request),
    .m_writeback_needed        (m_writeback_needed),
    .m_writeback_block_address (m_writeback_block_address),
    .m_forward_write           (m_forward_write)
);
